// ===== sv/pbc_pkg.sv =====
// Package for the Pascal binomial coefficient block.
// Holds field widths, the controller state type and the control/status structs.
// No dependencies.
package pbc_pkg;

    localparam int MAX_N_DEFAULT = 64;
    localparam int FIELD_W       = 7;    // n_total and k_chosen
    localparam int COEF_W        = 61;   // coefficient
    localparam int S_TDATA_W     = 16;   // two 7-bit fields, padded to bytes
    localparam int M_TDATA_W     = 64;   // 61-bit coefficient, padded to bytes

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_ROWS,
        ST_FETCH,
        ST_CAPTURE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch n and k of the accepted beat
        logic init_step;  // write one entry of row 0
        logic row_step;   // one column step of a Pascal row update
        logic fetch;      // read the final entry at column k
        logic capture;    // load the result register
    } pbc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic zero_case;  // k above n
        logic init_last;  // row 0 write at column k
        logic col_zero;   // last cycle of a row update
        logic rows_none;  // n is zero, no rows to build
        logic row_last;   // current row is the last one
    } pbc_status_t;

endpackage

// ===== sv/pbc_ctrl.sv =====
// Controller of the Pascal binomial coefficient block.
// Sequences row 0 setup, row updates, the final read and the output beat.
// Depends on pbc_pkg.
module pbc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output pbc_pkg::pbc_cmd_t   cmd,
    input  pbc_pkg::pbc_status_t status
);

    pbc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    // State register and output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pbc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pbc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = pbc_pkg::ST_SETUP;
            end
            pbc_pkg::ST_SETUP: begin
                state_next = status.zero_case ? pbc_pkg::ST_CAPTURE : pbc_pkg::ST_INIT;
            end
            pbc_pkg::ST_INIT: begin
                if (status.init_last)
                    state_next = status.rows_none ? pbc_pkg::ST_FETCH : pbc_pkg::ST_ROWS;
            end
            pbc_pkg::ST_ROWS: begin
                if (status.col_zero && status.row_last) state_next = pbc_pkg::ST_FETCH;
            end
            pbc_pkg::ST_FETCH: begin
                state_next = pbc_pkg::ST_CAPTURE;
            end
            pbc_pkg::ST_CAPTURE: begin
                if (out_free) state_next = pbc_pkg::ST_IDLE;
            end
            default: begin
                state_next = pbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            pbc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            pbc_pkg::ST_INIT: begin
                cmd.init_step = 1'b1;
            end
            pbc_pkg::ST_ROWS: begin
                cmd.row_step = 1'b1;
            end
            pbc_pkg::ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            pbc_pkg::ST_CAPTURE: begin
                if (out_free) begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== sv/pbc_dpath.sv =====
// Datapath of the Pascal binomial coefficient block.
// Row store memory, column and row counters, the shared adder, result register.
// Depends on pbc_pkg.
module pbc_dpath #(
    parameter int MAX_N = pbc_pkg::MAX_N_DEFAULT
) (
    input  logic                          aclk,
    input  logic [pbc_pkg::FIELD_W-1:0]   n_total,
    input  logic [pbc_pkg::FIELD_W-1:0]   k_chosen,
    input  pbc_pkg::pbc_cmd_t             cmd,
    output pbc_pkg::pbc_status_t          status,
    output logic [pbc_pkg::COEF_W-1:0]    coefficient
);

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_N + 2);
    localparam int CWX   = (CW > AW) ? CW : AW;

    logic [pbc_pkg::COEF_W-1:0] row_mem [DEPTH];

    logic [AW-1:0]              n_reg, k_reg;
    logic                       zero_reg;
    logic [CW-1:0]              col_reg, col_next;
    logic [AW-1:0]              row_reg, row_next;
    logic [pbc_pkg::COEF_W-1:0] rd_data_reg, hi_reg, coef_reg;

    logic [pbc_pkg::FIELD_W-1:0] n_clamped;
    logic [CWX-1:0]              col_x, k_x;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [pbc_pkg::COEF_W-1:0]  wr_data;

    // n saturates at MAX_N
    assign n_clamped = (n_total > pbc_pkg::FIELD_W'(MAX_N)) ?
                       pbc_pkg::FIELD_W'(MAX_N) : n_total;

    assign col_x = CWX'(col_reg);
    assign k_x   = CWX'(k_reg);

    // Status
    assign status.zero_case = zero_reg;
    assign status.init_last = (col_x == k_x);
    assign status.col_zero  = (col_reg == '0);
    assign status.rows_none = (n_reg == '0);
    assign status.row_last  = (row_reg == AW'(1));

    // Memory port control: row 0 fill, in-place row update, final read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(col_reg);
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = k_reg;
        if (cmd.init_step) begin
            wr_en   = 1'b1;
            wr_data = (col_reg == '0) ? pbc_pkg::COEF_W'(1) : '0;
        end
        if (cmd.row_step) begin
            // write column col+1 from the two values read earlier
            wr_en   = (col_x < k_x);
            wr_addr = AW'(col_reg + CW'(1));
            wr_data = hi_reg + rd_data_reg;
            // read column col-1, the lower neighbor of the next write
            rd_en   = (col_reg != '0);
            rd_addr = AW'(col_reg - CW'(1));
        end
        if (cmd.fetch) begin
            rd_en = 1'b1;
        end
    end

    // Counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load) begin
            col_next = '0;
            row_next = AW'(n_clamped);
        end else if (cmd.init_step) begin
            col_next = status.init_last ? CW'(k_x + CWX'(1)) : col_reg + CW'(1);
        end else if (cmd.row_step) begin
            if (col_reg == '0) begin
                col_next = CW'(k_x + CWX'(1));
                row_next = row_reg - AW'(1);
            end else begin
                col_next = col_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
        row_reg <= row_next;
        if (cmd.load) begin
            n_reg    <= AW'(n_clamped);
            k_reg    <= AW'(k_chosen);
            zero_reg <= (k_chosen > n_clamped);
        end
    end

    // Row store: one write and one read port, registered read data
    always_ff @(posedge aclk) begin
        if (wr_en) row_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= row_mem[rd_addr];
    end

    // Upper neighbor: registered copy of the read data, taken on each row step
    always_ff @(posedge aclk) begin
        if (cmd.row_step) hi_reg <= rd_data_reg;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.capture) coef_reg <= zero_reg ? '0 : rd_data_reg;
    end

    assign coefficient = coef_reg;

endmodule

// ===== sv/pascal_binomial_coefficient.sv =====
// Binomial coefficient C(n,k) by Pascal's rule over a single row store.
// Sequence from accepted beat to output beat: setup, row 0 fill of columns 0 to k,
// n row updates from column k+1 down to 0, fetch, capture; k above n skips to capture.
// One request at a time: no new beat is taken until the result is captured;
// a stalled output beat holds back the next capture.
// Reset: aresetn synchronous, active low; clears controller and output valid.
module pascal_binomial_coefficient #(
    parameter int MAX_N = pbc_pkg::MAX_N_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pbc_pkg::S_TDATA_W-1:0]  s_tdata,   // [6:0] n_total, [13:7] k_chosen
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pbc_pkg::M_TDATA_W-1:0]  m_tdata    // [60:0] coefficient
);

    pbc_pkg::pbc_cmd_t          cmd;
    pbc_pkg::pbc_status_t       status;
    logic [pbc_pkg::COEF_W-1:0] coefficient;

    pbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    pbc_dpath #(
        .MAX_N (MAX_N)
    ) u_dpath (
        .aclk        (aclk),
        .n_total     (s_tdata[pbc_pkg::FIELD_W-1:0]),
        .k_chosen    (s_tdata[2*pbc_pkg::FIELD_W-1:pbc_pkg::FIELD_W]),
        .cmd         (cmd),
        .status      (status),
        .coefficient (coefficient)
    );

    // Pad the coefficient up to whole bytes
    assign m_tdata = pbc_pkg::M_TDATA_W'(coefficient);

endmodule

// ===== sv/pbc_checker.sv =====
// Port-level checker for the Pascal binomial coefficient block.
// Bound to the top level; sees only its ports. Depends on pbc_pkg.
module pbc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [pbc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pbc_pkg::M_TDATA_W-1:0] m_tdata
);

    // No output beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled output beat holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    // One request at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // Padding bits above the coefficient stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[pbc_pkg::M_TDATA_W-1:pbc_pkg::COEF_W] == '0))
        else $error("nonzero padding in output beat");

    // An accepted beat with no output pending is not answered by an early output beat
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
        else $error("output beat too early");

endmodule

bind pascal_binomial_coefficient pbc_checker u_pbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
